@@ design/mse_pkg.sv @@
// Shared types, constants and codes for the merge sort engine.
// No dependencies; every other design file refers to it by scoped names.
package mse_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 1024;

    // action codes of an input item
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        logic  action;
        t_word value_in;
        logic  last_in;
    } t_mse_in;

    typedef struct packed {
        t_word value_out;
        logic  last_out;
        logic  empty_res;
    } t_mse_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_PRIME,
        ST_MERGE,
        ST_POP
    } t_mse_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // store a loaded value, open or extend the set
        logic pair;       // set up pointers and middle of the next run pair
        logic prime;      // first read of the run heads, set up the run end
        logic merge;      // move one element from source to destination
        logic sel_merge;  // read ports follow the merge pointers
        logic pass;       // pass over: swap buffers, double the run width
        logic finish;     // sort done, results may be popped
        logic emit;       // load the result register from the pop read
    } t_mse_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_sort; // the offered load closes the set
        logic multi;      // the closed set holds two or more values
        logic merge_end;  // this merge step writes the last element of the pair
        logic pass_end;   // no run pair left in this pass
        logic sort_end;   // this pass was the last one
        logic out_free;   // result register can take a new result
    } t_mse_stat;

endpackage

@@ design/merge_sort_engine.sv @@
// Merge sort engine top level: controller plus datapath with two sort buffers.
// Depends on mse_pkg, mse_buf, mse_ctrl and mse_datapath.
//
// Loads (action 0) store one signed value per transfer, one per cycle; the
// load with last_in set, or the one that fills the set to DEPTH values, closes
// the set and starts a bottom-up merge sort between two single-write,
// dual-read buffers. Input ready stays low while the sort runs. The sort makes
// ceil(log2(n)) passes over n values; each run pair of a pass takes a pair
// and a prime step, then moves one element per cycle, limited by the single
// write port of the destination buffer. A pop (action 1) is accepted and
// reads the buffer, then fills the result register once that is free; it
// answers with the next value in ascending order, last_out on the final one,
// or empty_res when nothing is left or no sort has finished.
// A load after a finished sort drops what is left and opens a new set. Equal
// values keep their load order. Loads are still accepted while a result waits
// in the output register. No clearing pass is needed after reset.
module merge_sort_engine #(
    parameter int DEPTH = mse_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mse_pkg::t_mse_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mse_pkg::t_mse_out o_out_data
);

    mse_pkg::t_mse_cmd  cmd;
    mse_pkg::t_mse_stat stat;

    // sequencing: handshake, pass and run-pair control
    mse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // buffers, pointers, compare and result register
    mse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ design/mse_buf.sv @@
// One sort buffer: one write port, two read ports with registered data.
// Depends on mse_pkg for the word type.
module mse_buf #(
    parameter int DEPTH = mse_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  mse_pkg::t_word      i_wdata,
    input  logic [AW-1:0]       i_raddr0,
    input  logic [AW-1:0]       i_raddr1,
    output mse_pkg::t_word      o_rdata0,
    output mse_pkg::t_word      o_rdata1
);

    mse_pkg::t_word r_mem [DEPTH];
    mse_pkg::t_word r_q0;
    mse_pkg::t_word r_q1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0 <= r_mem[i_raddr0];
        r_q1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_q0;
    assign o_rdata1 = r_q1;

endmodule

@@ design/mse_ctrl.sv @@
// Controller of the merge sort engine: input handshake and sort sequencing.
// Depends on mse_pkg for the state, command and status types.
module mse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_action,
    input  mse_pkg::t_mse_stat i_stat,
    output logic               o_in_ready,
    output mse_pkg::t_mse_cmd  o_cmd
);

    mse_pkg::t_mse_state r_state;
    mse_pkg::t_mse_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mse_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == mse_pkg::ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_stat.start_sort) begin
                            if (i_stat.multi) begin
                                n_state = mse_pkg::ST_PAIR;
                            end else begin
                                o_cmd.finish = 1'b1;
                            end
                        end
                    end else begin
                        n_state = mse_pkg::ST_POP;
                    end
                end
            end
            mse_pkg::ST_PAIR: begin
                o_cmd.pair = 1'b1;
                n_state    = mse_pkg::ST_PRIME;
            end
            mse_pkg::ST_PRIME: begin
                o_cmd.prime     = 1'b1;
                o_cmd.sel_merge = 1'b1;
                n_state         = mse_pkg::ST_MERGE;
            end
            mse_pkg::ST_MERGE: begin
                o_cmd.merge     = 1'b1;
                o_cmd.sel_merge = 1'b1;
                if (i_stat.merge_end) begin
                    n_state = mse_pkg::ST_PAIR;
                    if (i_stat.pass_end) begin
                        o_cmd.pass = 1'b1;
                        if (i_stat.sort_end) begin
                            o_cmd.finish = 1'b1;
                            n_state      = mse_pkg::ST_IDLE;
                        end
                    end
                end
            end
            mse_pkg::ST_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = mse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/mse_datapath.sv @@
// Datapath of the merge sort engine: both buffers, set and merge pointers,
// and the result register. Depends on mse_pkg and mse_buf.
module mse_datapath #(
    parameter int DEPTH = mse_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mse_pkg::t_mse_in   i_in_data,
    input  mse_pkg::t_mse_cmd  i_cmd,
    input  logic               i_out_ready,
    output mse_pkg::t_mse_stat o_stat,
    output logic               o_out_valid,
    output mse_pkg::t_mse_out  o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0] r_count,  n_count;
    logic [CW-1:0] r_rdpos,  n_rdpos;
    logic          r_sorted, n_sorted;
    logic          r_src,    n_src;
    logic [CW-1:0] r_width,  n_width;
    logic [CW-1:0] r_lo,     n_lo;
    logic [CW-1:0] r_i,      n_i;
    logic [CW-1:0] r_j,      n_j;
    logic [CW-1:0] r_k,      n_k;
    logic [CW-1:0] r_mid,    n_mid;
    logic [CW-1:0] r_hi,     n_hi;
    logic          r_out_valid, n_out_valid;
    mse_pkg::t_mse_out r_out, n_out;

    logic [CW-1:0] count_eff;
    logic [CW-1:0] count_inc;
    logic [CW:0]   mid_sum;
    logic [CW:0]   hi_sum;
    logic [CW-1:0] mid_val;
    logic [CW-1:0] hi_val;
    logic          a_ok;
    logic          b_ok;
    logic          take_b;
    logic          pop_ok;
    mse_pkg::t_word merge_val;
    mse_pkg::t_word rd_a;
    mse_pkg::t_word rd_b;
    mse_pkg::t_word a_q0, a_q1, b_q0, b_q1;

    logic          a_we;
    logic          b_we;
    logic [AW-1:0] a_waddr;
    mse_pkg::t_word a_wdata;
    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;

    // a load after a finished sort starts a fresh set
    assign count_eff = r_sorted ? '0 : r_count;
    assign count_inc = count_eff + CW'(1);

    // run boundaries, clipped to the set size
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_width};
    assign mid_val = (mid_sum >= {1'b0, r_count}) ? r_count : mid_sum[CW-1:0];
    assign hi_sum  = {1'b0, r_mid} + {1'b0, r_width};
    assign hi_val  = (hi_sum >= {1'b0, r_count}) ? r_count : hi_sum[CW-1:0];

    // read data of the current source buffer
    assign rd_a = r_src ? b_q0 : a_q0;
    assign rd_b = r_src ? b_q1 : a_q1;

    // merge choice: right head wins only when strictly smaller
    assign a_ok      = r_i < r_mid;
    assign b_ok      = r_j < r_hi;
    assign take_b    = b_ok && (!a_ok || (rd_b < rd_a));
    assign merge_val = take_b ? rd_b : rd_a;

    assign pop_ok = r_sorted && (r_rdpos < r_count);

    always_comb begin
        n_count     = r_count;
        n_rdpos     = r_rdpos;
        n_sorted    = r_sorted;
        n_src       = r_src;
        n_width     = r_width;
        n_lo        = r_lo;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_count  = count_inc;
            n_rdpos  = '0;
            n_sorted = 1'b0;
            n_src    = 1'b0;
            n_width  = CW'(1);
            n_lo     = '0;
        end
        if (i_cmd.pair) begin
            n_i   = r_lo;
            n_k   = r_lo;
            n_j   = mid_val;
            n_mid = mid_val;
        end
        if (i_cmd.prime) begin
            n_hi = hi_val;
            n_lo = hi_val;
        end
        if (i_cmd.merge) begin
            n_k = r_k + CW'(1);
            if (take_b) begin
                n_j = r_j + CW'(1);
            end else begin
                n_i = r_i + CW'(1);
            end
        end
        if (i_cmd.pass) begin
            n_src   = ~r_src;
            n_width = {r_width[CW-2:0], 1'b0};
            n_lo    = '0;
        end
        if (i_cmd.finish) begin
            n_sorted = 1'b1;
            n_rdpos  = '0;
        end
        if (i_cmd.emit) begin
            n_out_valid     = 1'b1;
            n_out.value_out = pop_ok ? rd_a : '0;
            n_out.last_out  = pop_ok && ((r_rdpos + CW'(1)) == r_count);
            n_out.empty_res = !pop_ok;
            if (pop_ok) begin
                n_rdpos = r_rdpos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rdpos     <= '0;
            r_sorted    <= 1'b0;
            r_src       <= 1'b0;
            r_width     <= CW'(1);
            r_lo        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rdpos     <= n_rdpos;
            r_sorted    <= n_sorted;
            r_src       <= n_src;
            r_width     <= n_width;
            r_lo        <= n_lo;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_out <= n_out;
    end

    // buffer A takes loads and the merges that read from B, B the merges that read from A
    assign a_we    = i_cmd.load || (i_cmd.merge && r_src);
    assign b_we    = i_cmd.merge && !r_src;
    assign a_waddr = i_cmd.load ? count_eff[AW-1:0] : r_k[AW-1:0];
    assign a_wdata = i_cmd.load ? i_in_data.value_in : merge_val;
    assign raddr0  = i_cmd.sel_merge ? n_i[AW-1:0] : r_rdpos[AW-1:0];
    assign raddr1  = n_j[AW-1:0];

    mse_buf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_buf_a (
        .i_clk    (i_clk),
        .i_we     (a_we),
        .i_waddr  (a_waddr),
        .i_wdata  (a_wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (a_q0),
        .o_rdata1 (a_q1)
    );

    mse_buf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_buf_b (
        .i_clk    (i_clk),
        .i_we     (b_we),
        .i_waddr  (r_k[AW-1:0]),
        .i_wdata  (merge_val),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (b_q0),
        .o_rdata1 (b_q1)
    );

    assign o_stat.start_sort = i_in_data.last_in || (count_inc == CW'(DEPTH));
    assign o_stat.multi      = count_inc >= CW'(2);
    assign o_stat.merge_end  = (r_k + CW'(1)) == r_hi;
    assign o_stat.pass_end   = r_lo >= r_count;
    assign o_stat.sort_end   = {r_width, 1'b0} >= {1'b0, r_count};
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("set count beyond depth");

    a_rdpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdpos <= r_count)
        else $error("read position beyond set count");

    a_merge_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (r_k < r_hi) && (r_i <= r_mid) && (r_j <= r_hi))
        else $error("merge write outside its run pair");

    a_merge_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (a_ok || b_ok))
        else $error("merge step with both runs exhausted");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_stat.out_free)
        else $error("result register overwritten while a transfer is pending");

endmodule
